/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define UHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define UHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/uhc_pkg.sv */
// Package with the types, constants and tables of the heading control law.
`default_nettype none
package uhc_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_CORD, S_OMUL, S_OMEGA, S_W2, S_S2, S_DEN, S_DIVI, S_DIV,
        S_EXP0, S_TMUL, S_TDIV, S_TCOR1, S_TCOR2, S_ILOOP, S_IRES, S_VOUT, S_DONE
    } t_state;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_TVEL  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam int          ATAN_ENTRIES  = 24;
    localparam logic [31:0] TWO_PI_SQ_Q16 = 32'd1293629;
    localparam logic [31:0] EXP_M1_Q30    = 32'd395007542;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
    localparam logic [21:0] U_LIMIT       = 22'd1572864;
    localparam logic [3:0]  TAYLOR_TERMS  = 4'd12;

    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Rounded-up reciprocals 2^32 / k for the Taylor term divisors.
    function automatic logic [31:0] recip(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd2:    v = 32'd2147483648;
            4'd3:    v = 32'd1431655766;
            4'd4:    v = 32'd1073741824;
            4'd5:    v = 32'd858993460;
            4'd6:    v = 32'd715827883;
            4'd7:    v = 32'd613566757;
            4'd8:    v = 32'd536870912;
            4'd9:    v = 32'd477218589;
            4'd10:   v = 32'd429496730;
            4'd11:   v = 32'd390451573;
            4'd12:   v = 32'd357913942;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Clamps a magnitude to the 24-bit output range and applies the sign.
    function automatic logic [23:0] sat_apply(input logic [31:0] mag, input logic neg);
        logic [31:0] lim;
        logic [23:0] m;
        lim = neg ? 32'd8388608 : 32'd8388607;
        m   = (mag > lim) ? lim[23:0] : mag[23:0];
        return neg ? (~m + 24'd1) : m;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/uhc_item_if.sv */
// Input request channel: command and reference vector.
`default_nettype none
interface uhc_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    modport source(output valid, cmd, ref_x, ref_y, input ready);
    modport sink(input valid, cmd, ref_x, ref_y, output ready);
endinterface
`default_nettype wire

/* rtl/core/uhc_result_if.sv */
// Result request channel: velocity and turn rate commands.
`default_nettype none
interface uhc_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] velocity;
    logic signed [23:0] omega;
    modport source(output valid, velocity, omega, input ready);
    modport sink(input valid, velocity, omega, output ready);
endinterface
`default_nettype wire

/* rtl/core/uhc_cfg_if.sv */
// Configuration write channel: register index and data.
`default_nettype none
interface uhc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/uhc_mul.sv */
// Shared unsigned 32 by 32 multiplier with a registered product.
`default_nettype none
module uhc_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

/* rtl/core/unicycle_heading_control_law_top.sv */
// Top level of the unicycle heading control law with its sequencer and datapath.
// A load request stores the reference vector. A tick request runs the lesser of
// CORDIC_ITERATIONS and 24 vectoring steps on the held vector, then all products go
// through one shared 32 by 32 multiplier: the turn rate, the exponent argument, the
// twelve Taylor terms, one multiply per whole unit of the exponent and the velocity.
// The exponent argument ends in a 22-step restoring division, and its integer part is
// at most 23 where the series runs. An exponent of 24 or more skips the series, and a
// zero reference goes straight to the done state. A finished tick waits there while a
// previous result still waits in the output register. The block takes no request
// while a tick is in work; a finished result waits in the output register while the
// next request is taken.
`default_nettype none
module unicycle_heading_control_law_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    uhc_item_if.sink     i_item,
    uhc_result_if.source o_result,
    uhc_cfg_if.sink      i_cfg
);
    localparam int NITER = (CORDIC_ITERATIONS < uhc_pkg::ATAN_ENTRIES) ?
                           CORDIC_ITERATIONS : uhc_pkg::ATAN_ENTRIES;
    localparam int IW = $clog2(NITER);
    localparam logic [IW-1:0] ILAST = IW'(NITER - 1);

    uhc_pkg::t_state r_state, n_state;

    logic [15:0]        r_gain, r_tvel, r_scale;
    logic [23:0]        r_hx, r_hy;
    logic               r_has;
    logic signed [35:0] r_cx, r_cy;
    logic signed [19:0] r_cz;
    logic [IW-1:0]      r_i;
    logic               r_dir_neg;
    logic [23:0]        r_omega, r_wabs, r_vel;
    logic [63:0]        r_num, r_rem;
    logic [74:0]        r_den_sh;
    logic [21:0]        r_q;
    logic [4:0]         r_dcnt, r_n;
    logic [29:0]        r_r30;
    logic [30:0]        r_term, r_a, r_e;
    logic signed [31:0] r_sum;
    logic [3:0]         r_k;
    logic               r_ovalid;
    logic [23:0]        r_ovel, r_oom;

    logic [31:0] n_mul_a, n_mul_b;
    logic [63:0] mul_p;
    logic        in_acc, out_load;

    logic signed [24:0] ext_x, ext_y, nx, ny;
    logic signed [35:0] dx, dy;
    logic [16:0]        gain_abs, tv_abs, atan_v;
    logic [19:0]        z_abs;
    logic [15:0]        scale_eff;
    logic [39:0]        om_round;
    logic [31:0]        om_mag;
    logic               om_neg;
    logic [23:0]        om_sat, om_wabs;
    logic               div_ge;
    logic [30:0]        tdiv_a, tcor_q, tcor_t;
    logic signed [31:0] sum_next;
    logic [47:0]        vel_round;
    logic [31:0]        vel_mag;

    uhc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (mul_p)
    );

    assign i_item.ready      = (r_state == uhc_pkg::S_IDLE);
    assign in_acc            = i_item.valid && i_item.ready;
    assign i_cfg.ready       = 1'b1;
    assign o_result.valid    = r_ovalid;
    assign o_result.velocity = r_ovel;
    assign o_result.omega    = r_oom;
    assign out_load          = (r_state == uhc_pkg::S_DONE) && (!r_ovalid || o_result.ready);

    always_comb begin
        ext_x     = {r_hx[23], r_hx};
        ext_y     = {r_hy[23], r_hy};
        nx        = r_hx[23] ? -ext_x : ext_x;
        ny        = r_hx[23] ? -ext_y : ext_y;
        dx        = r_cy >>> r_i;
        dy        = r_cx >>> r_i;
        atan_v    = uhc_pkg::atan_q16(5'(r_i));
        gain_abs  = r_gain[15] ? (17'd0 - {1'b1, r_gain}) : {1'b0, r_gain};
        tv_abs    = r_tvel[15] ? (17'd0 - {1'b1, r_tvel}) : {1'b0, r_tvel};
        z_abs     = r_cz[19] ? 20'(-r_cz) : 20'(r_cz);
        scale_eff = (r_scale == 16'd0) ? 16'd1 : r_scale;
        om_round  = mul_p[39:0] + 40'd128;
        om_mag    = om_round[39:8];
        om_neg    = r_gain[15] ^ r_cz[19];
        om_sat    = uhc_pkg::sat_apply(om_mag, om_neg);
        om_wabs   = om_neg ? (24'd0 - om_sat) : om_sat;
        div_ge    = {11'd0, r_rem} >= r_den_sh;
        tdiv_a    = mul_p[60:30];
        tcor_q    = (r_k == 4'd1) ? r_a : mul_p[62:32];
        tcor_t    = (mul_p > {33'd0, r_a}) ? (r_term - 31'd1) : r_term;
        sum_next  = r_k[0] ? (r_sum - $signed({1'b0, tcor_t}))
                           : (r_sum + $signed({1'b0, tcor_t}));
        vel_round = mul_p[47:0] + 48'd2097152;
        vel_mag   = {6'd0, vel_round[47:22]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uhc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mul_a = 32'd0;
        n_mul_b = 32'd0;
        unique case (r_state)
            uhc_pkg::S_IDLE: begin
                if (in_acc && i_item.cmd == uhc_pkg::CMD_TICK && r_has) begin
                    n_state = (r_hx == 24'd0 && r_hy == 24'd0) ?
                              uhc_pkg::S_DONE : uhc_pkg::S_CORD;
                end
            end
            uhc_pkg::S_CORD: begin
                if (r_i == ILAST) begin
                    n_state = uhc_pkg::S_OMUL;
                end
            end
            uhc_pkg::S_OMUL: begin
                n_mul_a = 32'(gain_abs);
                n_mul_b = 32'(z_abs);
                n_state = uhc_pkg::S_OMEGA;
            end
            uhc_pkg::S_OMEGA: begin
                n_state = uhc_pkg::S_W2;
            end
            uhc_pkg::S_W2: begin
                n_mul_a = 32'(r_wabs);
                n_mul_b = 32'(r_wabs);
                n_state = uhc_pkg::S_S2;
            end
            uhc_pkg::S_S2: begin
                n_mul_a = 32'(scale_eff);
                n_mul_b = 32'(scale_eff);
                n_state = uhc_pkg::S_DEN;
            end
            uhc_pkg::S_DEN: begin
                n_mul_a = mul_p[31:0];
                n_mul_b = uhc_pkg::TWO_PI_SQ_Q16;
                n_state = uhc_pkg::S_DIVI;
            end
            uhc_pkg::S_DIVI: begin
                n_state = uhc_pkg::S_DIV;
            end
            uhc_pkg::S_DIV: begin
                if (r_dcnt == 5'd0) begin
                    n_state = uhc_pkg::S_EXP0;
                end
            end
            uhc_pkg::S_EXP0: begin
                n_state = (r_q[21] || r_q >= uhc_pkg::U_LIMIT) ?
                          uhc_pkg::S_ILOOP : uhc_pkg::S_TMUL;
            end
            uhc_pkg::S_TMUL: begin
                n_mul_a = 32'(r_term);
                n_mul_b = 32'(r_r30);
                n_state = uhc_pkg::S_TDIV;
            end
            uhc_pkg::S_TDIV: begin
                n_mul_a = 32'(tdiv_a);
                n_mul_b = uhc_pkg::recip(r_k);
                n_state = uhc_pkg::S_TCOR1;
            end
            uhc_pkg::S_TCOR1: begin
                n_mul_a = 32'(tcor_q);
                n_mul_b = 32'(r_k);
                n_state = uhc_pkg::S_TCOR2;
            end
            uhc_pkg::S_TCOR2: begin
                n_state = (r_k == uhc_pkg::TAYLOR_TERMS) ?
                          uhc_pkg::S_ILOOP : uhc_pkg::S_TMUL;
            end
            uhc_pkg::S_ILOOP: begin
                if (r_n == 5'd0) begin
                    n_mul_a = 32'(tv_abs);
                    n_mul_b = 32'(r_e);
                    n_state = uhc_pkg::S_VOUT;
                end else begin
                    n_mul_a = 32'(r_e);
                    n_mul_b = uhc_pkg::EXP_M1_Q30;
                    n_state = uhc_pkg::S_IRES;
                end
            end
            uhc_pkg::S_IRES: begin
                n_state = uhc_pkg::S_ILOOP;
            end
            uhc_pkg::S_VOUT: begin
                n_state = uhc_pkg::S_DONE;
            end
            uhc_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = uhc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = uhc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 16'd256;
            r_tvel  <= 16'd256;
            r_scale <= 16'd256;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                uhc_pkg::REG_GAIN:  r_gain  <= i_cfg.data;
                uhc_pkg::REG_TVEL:  r_tvel  <= i_cfg.data;
                uhc_pkg::REG_SCALE: r_scale <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has <= 1'b0;
        end else if (in_acc && i_item.cmd == uhc_pkg::CMD_LOAD) begin
            r_has <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ovel <= r_vel;
            r_oom  <= r_omega;
        end
        unique case (r_state)
            uhc_pkg::S_IDLE: begin
                if (in_acc && i_item.cmd == uhc_pkg::CMD_LOAD) begin
                    r_hx <= i_item.ref_x;
                    r_hy <= i_item.ref_y;
                end
                r_cx      <= {{3{nx[24]}}, nx, 8'd0};
                r_cy      <= {{3{ny[24]}}, ny, 8'd0};
                r_cz      <= 20'sd0;
                r_i       <= '0;
                r_dir_neg <= r_hx[23];
                r_omega   <= 24'd0;
                r_vel     <= 24'd0;
            end
            uhc_pkg::S_CORD: begin
                if (r_cy > 36'sd0) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_cz <= r_cz + $signed({3'd0, atan_v});
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_cz <= r_cz - $signed({3'd0, atan_v});
                end
                r_i <= r_i + IW'(1);
            end
            uhc_pkg::S_OMEGA: begin
                r_omega <= om_sat;
                r_wabs  <= om_wabs;
            end
            uhc_pkg::S_S2: begin
                r_num <= {mul_p[47:0], 16'd0};
            end
            uhc_pkg::S_DIVI: begin
                r_den_sh <= {mul_p[53:0], 21'd0};
                r_rem    <= r_num;
                r_q      <= 22'd0;
                r_dcnt   <= 5'd21;
            end
            uhc_pkg::S_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_den_sh[63:0];
                end
                r_q      <= {r_q[20:0], div_ge};
                r_den_sh <= r_den_sh >> 1;
                r_dcnt   <= r_dcnt - 5'd1;
            end
            uhc_pkg::S_EXP0: begin
                if (r_q[21] || r_q >= uhc_pkg::U_LIMIT) begin
                    r_e <= 31'd0;
                    r_n <= 5'd0;
                end else begin
                    r_n <= r_q[20:16];
                end
                r_r30  <= {r_q[15:0], 14'd0};
                r_term <= uhc_pkg::ONE_Q30;
                r_sum  <= $signed({1'b0, uhc_pkg::ONE_Q30});
                r_k    <= 4'd1;
            end
            uhc_pkg::S_TDIV: begin
                r_a <= tdiv_a;
            end
            uhc_pkg::S_TCOR1: begin
                r_term <= tcor_q;
            end
            uhc_pkg::S_TCOR2: begin
                r_term <= tcor_t;
                r_sum  <= sum_next;
                r_k    <= r_k + 4'd1;
                r_e    <= sum_next[30:0];
            end
            uhc_pkg::S_IRES: begin
                r_e <= mul_p[60:30];
                r_n <= r_n - 5'd1;
            end
            uhc_pkg::S_VOUT: begin
                r_vel <= uhc_pkg::sat_apply(vel_mag, r_tvel[15] ^ r_dir_neg);
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/uhc_chk.sv */
// Port checker for the heading control law top level and its bind.
`default_nettype none
`include "assert_macros.svh"
module uhc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [23:0] i_out_velocity,
    input wire logic [23:0] i_out_omega,
    input wire logic        i_cfg_ready
);
    `UHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_velocity) && $stable(i_out_omega))
    `UHC_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready)
    `UHC_ASSERT_SAME(a_no_early_result, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready))
endmodule

bind unicycle_heading_control_law_top uhc_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_velocity (o_result.velocity),
    .i_out_omega    (o_result.omega),
    .i_cfg_ready    (i_cfg.ready)
);
`default_nettype wire
